// ===== hdl/iba_pkg.sv =====
// Shared widths, codes and reset values for the impulse band accumulator.
// No dependencies; every other file of the block imports this package.
package iba_pkg;

    localparam int BANDS     = 8;
    localparam int OP_W      = 2;
    localparam int TIME_W    = 21;
    localparam int RATE_W    = 18;
    localparam int SIDX_W    = 16;
    localparam int VOL_W     = 16;
    localparam int SUM_W     = 32;
    localparam int LEN_W     = 17;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = TIME_W + RATE_W;
    localparam int IDX_W     = PROD_W - FRAC_W;
    localparam int DEPTH_DEF = 65536;
    localparam int LEN_MAX   = 131071;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [RATE_W-1:0] RATE_RST  = RATE_W'(44100);
    localparam logic [TIME_W-1:0] LIMIT_RST = TIME_W'(1310720);

    // Operation codes carried by a request.
    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN  = 2'd2;

    // Register select, taken from the word address bit of paddr.
    localparam logic REG_RATE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef logic [BANDS-1:0][SUM_W-1:0] band_vec_t;
    typedef logic [BANDS-1:0][VOL_W-1:0] vol_vec_t;

endpackage

// ===== hdl/iba_if.sv =====
// Request and result channel interfaces of the impulse band accumulator.
// Depends on iba_pkg for the field widths.
interface iba_req_if;
    import iba_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [TIME_W-1:0]        impulse_time;
    logic [SIDX_W-1:0]        sample_index;
    logic signed [VOL_W-1:0]  vol_band0;
    logic signed [VOL_W-1:0]  vol_band1;
    logic signed [VOL_W-1:0]  vol_band2;
    logic signed [VOL_W-1:0]  vol_band3;
    logic signed [VOL_W-1:0]  vol_band4;
    logic signed [VOL_W-1:0]  vol_band5;
    logic signed [VOL_W-1:0]  vol_band6;
    logic signed [VOL_W-1:0]  vol_band7;

    modport source (
        output valid, op, impulse_time, sample_index,
        output vol_band0, vol_band1, vol_band2, vol_band3,
        output vol_band4, vol_band5, vol_band6, vol_band7,
        input  ready
    );

    modport sink (
        input  valid, op, impulse_time, sample_index,
        input  vol_band0, vol_band1, vol_band2, vol_band3,
        input  vol_band4, vol_band5, vol_band6, vol_band7,
        output ready
    );
endinterface

interface iba_rsp_if;
    import iba_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SUM_W-1:0]  sum_band0;
    logic signed [SUM_W-1:0]  sum_band1;
    logic signed [SUM_W-1:0]  sum_band2;
    logic signed [SUM_W-1:0]  sum_band3;
    logic signed [SUM_W-1:0]  sum_band4;
    logic signed [SUM_W-1:0]  sum_band5;
    logic signed [SUM_W-1:0]  sum_band6;
    logic signed [SUM_W-1:0]  sum_band7;
    logic [LEN_W-1:0]         run_length;

    modport source (
        output valid, sum_band0, sum_band1, sum_band2, sum_band3,
        output sum_band4, sum_band5, sum_band6, sum_band7, run_length,
        input  ready
    );

    modport sink (
        input  valid, sum_band0, sum_band1, sum_band2, sum_band3,
        input  sum_band4, sum_band5, sum_band6, sum_band7, run_length,
        output ready
    );
endinterface

// ===== hdl/iba_t2i.sv =====
// Time to sample index converter: registered time * rate product, then
// round half up and drop the Q16 fraction. Depends on iba_pkg.
module iba_t2i (
    input  logic                       clk,
    input  logic [iba_pkg::TIME_W-1:0] tm,
    input  logic [iba_pkg::RATE_W-1:0] rate,
    output logic [iba_pkg::IDX_W-1:0]  idx
);
    import iba_pkg::*;

    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_W - 1);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] rounded;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(tm) * PROD_W'(rate);
    end

    // The product stays below 2^39 - 2^21, so adding half an LSB cannot carry out.
    assign rounded = prod_reg + HALF;
    assign idx     = rounded[PROD_W-1:FRAC_W];

endmodule

// ===== hdl/impulse_band_accumulator.sv =====
// An add passes through multiply, lookup and write-back; a read through lookup
// and write-back, which waits while the full output register is not taken, and
// then shows its result there. A new-run op resets the run length in idle, one
// per cycle. Requests are taken only in idle, so an add or read ends before the
// next is taken. Reset: control clears at once, then a pass writes zeros to
// every store entry while req.ready stays low; register writes are taken then.
module impulse_band_accumulator #(
    parameter int DEPTH = iba_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    iba_req_if.sink                     req,
    iba_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [iba_pkg::PADDR_W-1:0] paddr,
    input  logic [iba_pkg::PDATA_W-1:0] pwdata,
    output logic [iba_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import iba_pkg::*;

    localparam int AW      = $clog2(DEPTH);
    localparam int LEN_CAP = (DEPTH < LEN_MAX) ? DEPTH : LEN_MAX;
    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W:0]   CAP_X     = (IDX_W + 1)'(LEN_CAP);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_LOOK  = 3'd3;
    localparam logic [2:0] ST_WB    = 3'd4;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [VOL_W-1:0] v);
        logic [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {{(SUM_W + 1 - VOL_W){v[VOL_W-1]}}, v};
        if (s[SUM_W] != s[SUM_W-1])
            return s[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
        return s[SUM_W-1:0];
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [TIME_W-1:0] limit_reg;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              out_valid_reg;
    band_vec_t         sum_reg;
    logic [LEN_W-1:0]  runlen_reg;

    logic [OP_W-1:0]   op_reg;
    logic [TIME_W-1:0] time_reg;
    logic [SIDX_W-1:0] sidx_reg;
    vol_vec_t          vol_reg;
    vol_vec_t          vol_in;
    logic [AW-1:0]     addr_reg;
    logic              hit_reg;

    band_vec_t         mem [DEPTH];
    band_vec_t         rdata_reg;
    band_vec_t         wdata;
    band_vec_t         acc;
    logic              mem_we;
    logic [AW-1:0]     waddr;

    logic [IDX_W-1:0]  item_idx;
    logic [IDX_W-1:0]  lim_idx;
    logic [IDX_W-1:0]  low_idx;
    logic [IDX_W:0]    cand_len;
    logic [AW-1:0]     look_addr;
    logic              look_hit;
    logic              req_take;
    logic              slot_free;
    logic              cfg_wr;

    iba_t2i u_item_t2i (
        .clk  (clk),
        .tm   (time_reg),
        .rate (rate_reg),
        .idx  (item_idx)
    );

    iba_t2i u_limit_t2i (
        .clk  (clk),
        .tm   (limit_reg),
        .rate (rate_reg),
        .idx  (lim_idx)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[PADDR_W-1] == REG_LIMIT) ? PDATA_W'(limit_reg)
                                                     : PDATA_W'(rate_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RATE_RST;
            limit_reg <= LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[PADDR_W-1] == REG_RATE)
                rate_reg <= pwdata[RATE_W-1:0];
            else
                limit_reg <= pwdata[TIME_W-1:0];
        end
    end

    // Request side.
    assign req.ready = (state_reg == ST_IDLE);
    assign req_take  = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        vol_in[0] = req.vol_band0;
        vol_in[1] = req.vol_band1;
        vol_in[2] = req.vol_band2;
        vol_in[3] = req.vol_band3;
        vol_in[4] = req.vol_band4;
        vol_in[5] = req.vol_band5;
        vol_in[6] = req.vol_band6;
        vol_in[7] = req.vol_band7;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            op_reg   <= req.op;
            time_reg <= req.impulse_time;
            sidx_reg <= req.sample_index;
            vol_reg  <= vol_in;
        end
    end

    // Lookup: pick the entry and decide whether the store is touched.
    always_comb
    begin
        low_idx  = (item_idx < lim_idx) ? item_idx : lim_idx;
        cand_len = {1'b0, low_idx} + (IDX_W + 1)'(1);
        if (cand_len > CAP_X)
            cand_len = CAP_X;
        if (op_reg == OP_ADD)
        begin
            look_addr = AW'(item_idx);
            look_hit  = (item_idx <= lim_idx) && ({1'b0, item_idx} < DEPTH_X);
        end
        else
        begin
            look_addr = AW'(sidx_reg);
            look_hit  = (IDX_W + 1)'(sidx_reg) < DEPTH_X;
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (req_take && req.op == OP_RUN)
            len_next = LEN_W'(1);
        else if (state_reg == ST_LOOK && op_reg == OP_ADD
                 && cand_len > (IDX_W + 1)'(len_reg))
            len_next = cand_len[LEN_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_addr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (req_take)
                begin
                    if (req.op == OP_ADD)
                        state_next = ST_MUL;
                    else if (req.op == OP_READ)
                        state_next = ST_LOOK;
                end
            ST_MUL:
                state_next = ST_LOOK;
            ST_LOOK:
                state_next = ST_WB;
            ST_WB:
                if (op_reg == OP_ADD || slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            len_reg      <= LEN_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOK)
        begin
            addr_reg <= look_addr;
            hit_reg  <= look_hit;
        end
    end

    // Sample store: one write port, one registered read port.
    always_comb
    begin
        for (int b = 0; b < BANDS; b++)
            acc[b] = sat_add(rdata_reg[b], vol_reg[b]);
    end

    always_comb
    begin
        mem_we = 1'b0;
        waddr  = addr_reg;
        wdata  = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
            waddr  = clr_addr_reg;
        end
        else if (state_reg == ST_WB && hit_reg)
        begin
            if (op_reg == OP_ADD)
            begin
                mem_we = 1'b1;
                wdata  = acc;
            end
            else
                mem_we = slot_free;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (state_reg == ST_LOOK)
            rdata_reg <= mem[look_addr];
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_WB && op_reg == OP_READ && slot_free)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WB && op_reg == OP_READ && slot_free)
        begin
            sum_reg    <= hit_reg ? rdata_reg : '0;
            runlen_reg <= len_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.sum_band0  = sum_reg[0];
    assign rsp.sum_band1  = sum_reg[1];
    assign rsp.sum_band2  = sum_reg[2];
    assign rsp.sum_band3  = sum_reg[3];
    assign rsp.sum_band4  = sum_reg[4];
    assign rsp.sum_band5  = sum_reg[5];
    assign rsp.sum_band6  = sum_reg[6];
    assign rsp.sum_band7  = sum_reg[7];
    assign rsp.run_length = runlen_reg;

`ifndef SYNTH
    // The run length never leaves the range 1 to its ceiling.
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) && ((IDX_W + 1)'(len_reg) <= CAP_X))
        else $error("run length out of range");

    // A taken read request goes straight to the store lookup.
    a_read_look: assert property (@(posedge clk) disable iff (!rst_n)
        req_take && req.op == OP_READ |=> state_reg == ST_LOOK)
        else $error("read request did not reach lookup");

    // A new result only appears as the write-back of a read finishes.
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_WB && $past(op_reg) == OP_READ)
        else $error("result raised outside read write-back");

    // The store is never written while an add is still waiting for its index.
    a_no_early_wr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL || state_reg == ST_LOOK |-> !mem_we)
        else $error("store written before lookup completed");
`endif

endmodule
